@@ hdl/xml_entity_escaper_core_defines.svh @@
// Assertion macros for the XML entity escaper.
`ifndef XML_ENTITY_ESCAPER_CORE_DEFINES_SVH
`define XML_ENTITY_ESCAPER_CORE_DEFINES_SVH

// Same-cycle implication.
`define XEE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define XEE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/xee_pkg.sv @@
// Shared types and character constants for the XML entity escaper.
package xee_pkg;

    localparam int RUN_MAX   = 6;
    localparam int RUN_LEN_W = $clog2(RUN_MAX + 1);
    localparam int RUN_IDX_W = $clog2(RUN_MAX);

    localparam logic [7:0] CTRL_LIMIT = 8'd32;
    localparam logic [7:0] HIGH_LIMIT = 8'd128;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_L    = 8'h6C;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_O    = 8'h6F;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_Q    = 8'h71;
    localparam logic [7:0] CH_S    = 8'h73;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_U    = 8'h75;

    // One escaped run: bytes[0] goes out first.
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_LEN_W-1:0]    len;
    } run_t;

endpackage

@@ hdl/xee_decode.sv @@
// Combinational decode of one text byte into its escaped run.
module xee_decode (
    input  logic          [7:0] in_byte,
    input  logic                mask_special,
    output xee_pkg::run_t       run
);
    import xee_pkg::*;

    logic        hund_two;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones_full;
    logic [3:0]  ones;

    // Decimal digits of a high byte: 128..255, hundreds digit 1 or 2.
    always_comb
    begin
        hund_two  = (in_byte >= 8'd200);
        rem       = hund_two ? 7'(in_byte - 8'd200) : 7'(in_byte - 8'd100);
        prod      = {8'd0, rem} * 15'd205;   // /10 for values below 100
        tens      = prod[14:11];
        ones_full = rem - ({3'd0, tens} * 7'd10);
        ones      = ones_full[3:0];
    end

    always_comb
    begin
        run       = '0;
        run.len   = RUN_LEN_W'(1);
        run.bytes[0] = in_byte;
        case (in_byte)
            CH_LT:
            begin
                run.bytes = '0;
                run.bytes[0] = CH_AMP; run.bytes[1] = CH_L;
                run.bytes[2] = CH_T;   run.bytes[3] = CH_SEMI;
                run.len = RUN_LEN_W'(4);
            end
            CH_GT:
            begin
                run.bytes = '0;
                run.bytes[0] = CH_AMP; run.bytes[1] = CH_G;
                run.bytes[2] = CH_T;   run.bytes[3] = CH_SEMI;
                run.len = RUN_LEN_W'(4);
            end
            CH_AMP:
            begin
                run.bytes = '0;
                run.bytes[0] = CH_AMP; run.bytes[1] = CH_A;
                run.bytes[2] = CH_M;   run.bytes[3] = CH_P;
                run.bytes[4] = CH_SEMI;
                run.len = RUN_LEN_W'(5);
            end
            CH_QUOT:
            begin
                run.bytes[0] = CH_AMP; run.bytes[1] = CH_Q;
                run.bytes[2] = CH_U;   run.bytes[3] = CH_O;
                run.bytes[4] = CH_T;   run.bytes[5] = CH_SEMI;
                run.len = RUN_LEN_W'(6);
            end
            CH_APOS:
            begin
                run.bytes[0] = CH_AMP; run.bytes[1] = CH_A;
                run.bytes[2] = CH_P;   run.bytes[3] = CH_O;
                run.bytes[4] = CH_S;   run.bytes[5] = CH_SEMI;
                run.len = RUN_LEN_W'(6);
            end
            default:
            begin
                if (mask_special && (in_byte < CTRL_LIMIT))
                begin
                    run.len = '0;
                end
                else if (mask_special && (in_byte >= HIGH_LIMIT))
                begin
                    run.bytes[0] = CH_AMP;
                    run.bytes[1] = CH_HASH;
                    run.bytes[2] = hund_two ? (CH_ZERO + 8'd2) : (CH_ZERO + 8'd1);
                    run.bytes[3] = CH_ZERO + {4'd0, tens};
                    run.bytes[4] = CH_ZERO + {4'd0, ones};
                    run.bytes[5] = CH_SEMI;
                    run.len = RUN_LEN_W'(6);
                end
            end
        endcase
    end

endmodule

@@ hdl/xee_emit.sv @@
// Run register and output register: sends a decoded run one word per cycle while the output is not stalled.
module xee_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  xee_pkg::run_t       run_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic          [7:0] out_byte,
    output logic                run_last
);
    import xee_pkg::*;

    run_t                 run_reg;
    logic                 run_valid_reg;
    logic [RUN_IDX_W-1:0] idx_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg;

    logic out_free;
    logic move;
    logic move_last;
    logic accept;

    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        move      = run_valid_reg && out_free;
        move_last = move && ({1'b0, idx_reg} == ({1'b0, run_reg.len} - 1'b1));
        in_stall  = run_valid_reg && !move_last;
        accept    = in_valid && !in_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                run_valid_reg <= (run_in.len != '0);
                idx_reg       <= '0;
            end
            else if (move_last)
            begin
                run_valid_reg <= 1'b0;
            end
            else if (move)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (move)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            run_reg <= run_in;
        if (move)
        begin
            out_byte_reg <= run_reg.bytes[idx_reg];
            out_last_reg <= move_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = out_last_reg;

endmodule

@@ hdl/xml_entity_escaper_core.sv @@
// XML predefined-entity escaper, top level.
//
// Input channel: in_valid / in_stall / in_byte, one text byte per word.
// Output channel: out_valid / out_stall / out_byte / run_last, one escaped
// byte per word; run_last marks the final byte produced for an input byte.
// Configuration: cfg_wr_en / cfg_wr_data write mask_special; the user must
// write it only when idle, as the block does not enforce this. An input byte
// is decoded as it is accepted into a run register holding up to six bytes;
// the run drains one byte per cycle, unless the output stalls, into the
// output register. Throughput: one input byte per cycle for runs of one
// byte unless the output stalls; an input byte holds the run register until
// its last byte (up to six) moves into the single output register.
// Bytes that produce nothing (control bytes with masking on) give no word.
// A stalled output holds its word; the run register waits and in_stall rises.
// Reset clears mask_special and all valid state; no words are in flight.
module xml_entity_escaper_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last
);
    import xee_pkg::*;

    `include "xml_entity_escaper_core_defines.svh"

    logic mask_special_reg;
    run_t dec_run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_special_reg <= 1'b0;
        else if (cfg_wr_en)
            mask_special_reg <= cfg_wr_data;
    end

    xee_decode u_decode (
        .in_byte      (in_byte),
        .mask_special (mask_special_reg),
        .run          (dec_run)
    );

    xee_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .run_in    (dec_run),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

    // A run never has a gap between its bytes.
    `XEE_ASSERT_NXT(a_run_contig, clk, rst_n, out_valid && !run_last, out_valid, "gap inside escaped run")

    // The five special characters never leave as a whole run.
    `XEE_ASSERT_NOW(a_no_raw_special, clk, rst_n, out_valid && run_last, (out_byte != CH_LT) && (out_byte != CH_GT) && (out_byte != CH_AMP) && (out_byte != CH_QUOT) && (out_byte != CH_APOS), "unescaped special character")

    // Only the ampersand opens a multi-byte run.
    `XEE_ASSERT_NXT(a_run_opens_amp, clk, rst_n, !(out_valid && !run_last), !(out_valid && !run_last) || (out_byte == CH_AMP), "multi-byte run not opened by ampersand")

endmodule

@@ dv/tb_xml_entity_escaper_core.sv @@
// Testbench for the XML entity escaper: a queue-fed driver, a stalling monitor and a run predictor.
`timescale 1ns / 100ps

module tb_xml_entity_escaper_core;
    import xee_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_WORDS  = 73;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } esc_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;

    logic [7:0] text_q [$];
    esc_word_t  esc_q [$];
    esc_word_t  got;
    logic       mask_on = 1'b0;
    int         errors = 0;
    int         cycles = 0;
    int         burst_left = 0;
    int         gap_left = 0;
    int         stall_mode = 0;
    int         stall_phase = 0;

    xml_entity_escaper_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // bytes[0] leaves first, so runs are written right to left
    function automatic run_t escape_run(input logic [7:0] b, input logic masked);
        run_t r;
        r = '0;
        case (b)
            CH_LT:
            begin
                r.bytes = {16'h0, CH_SEMI, CH_T, CH_L, CH_AMP};
                r.len = 4;
            end
            CH_GT:
            begin
                r.bytes = {16'h0, CH_SEMI, CH_T, CH_G, CH_AMP};
                r.len = 4;
            end
            CH_AMP:
            begin
                r.bytes = {8'h0, CH_SEMI, CH_P, CH_M, CH_A, CH_AMP};
                r.len = 5;
            end
            CH_QUOT:
            begin
                r.bytes = {CH_SEMI, CH_T, CH_O, CH_U, CH_Q, CH_AMP};
                r.len = 6;
            end
            CH_APOS:
            begin
                r.bytes = {CH_SEMI, CH_S, CH_O, CH_P, CH_A, CH_AMP};
                r.len = 6;
            end
            default:
            begin
                if (masked && b < CTRL_LIMIT)
                    r.len = 0;
                else if (masked && b >= HIGH_LIMIT)
                begin
                    r.bytes = {CH_SEMI,
                               8'(CH_ZERO + b % 8'd10),
                               8'(CH_ZERO + (b / 8'd10) % 8'd10),
                               8'(CH_ZERO + b / 8'd100),
                               CH_HASH, CH_AMP};
                    r.len = 6;
                end
                else
                begin
                    r.bytes[0] = b;
                    r.len = 1;
                end
            end
        endcase
        return r;
    endfunction

    task automatic expect_escaped(input logic [7:0] b);
        run_t r;
        r = escape_run(b, mask_on);
        for (int k = 0; k < int'(r.len); k++)
            esc_q.push_back('{ch: r.bytes[k], last: (k == int'(r.len) - 1)});
    endtask

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] specials [5];
        specials = '{CH_LT, CH_GT, CH_AMP, CH_QUOT, CH_APOS};
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'($urandom_range(32, 127));
            3, 4:    return specials[$urandom_range(0, 4)];
            5, 6:    return 8'($urandom_range(128, 255));
            7:       return 8'($urandom_range(0, 31));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // driver: bursts of words with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte <= 8'h00;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expect_escaped(in_byte);
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (text_q.size() != 0)
                begin
                    in_byte <= text_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and output stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_mode <= 0;
            stall_phase <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (esc_q.size() == 0)
                begin
                    $error("unexpected word: out_byte %h run_last %b", out_byte, run_last);
                    errors++;
                end
                else
                begin
                    got = esc_q.pop_front();
                    if (out_byte !== got.ch)
                    begin
                        $error("out_byte: expected %h, got %h", got.ch, out_byte);
                        errors++;
                    end
                    if (run_last !== got.last)
                    begin
                        $error("run_last: expected %b, got %b", got.last, run_last);
                        errors++;
                    end
                end
            end
            if (stall_phase == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_phase <= $urandom_range(16, 96);
            end
            else
                stall_phase <= stall_phase - 1;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= stall_phase[2];
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (text_q.size() != 0 || in_valid || esc_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mask(input logic v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        mask_on = v;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // masking off from reset: control and high bytes copied
        text_q = '{8'h00, 8'h1F, 8'h20, 8'h7F, 8'h80, 8'hFF,
                   CH_LT, CH_GT, CH_AMP, CH_QUOT, CH_APOS};
        wait_drained();

        write_mask(1'b1);
        @(negedge clk);
        text_q = '{8'h00, 8'h1F, 8'h20, 8'h7F, 8'h80, 8'h64, 8'hC7, 8'hFF,
                   CH_LT, CH_GT, CH_AMP, CH_QUOT, CH_APOS};
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            write_mask((p % 2 == 0) ? 1'b0 : 1'b1);
            @(negedge clk);
            for (int i = 0; i < PHASE_WORDS; i++)
                text_q.push_back(rand_text_byte());
            wait_drained();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
